@@ design/ccs_pkg.sv @@
// shared types, character codes and lexer step function for the comment stripper
`timescale 1ns / 1ps

package ccs_pkg;

   localparam int MaxResults = 4;
   localparam int CountWidth = $clog2(MaxResults + 1);

   // character codes
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_DQ    = 8'h22;

   // result kinds
   localparam logic [1:0] KIND_DATA       = 2'd0;
   localparam logic [1:0] KIND_END_OK     = 2'd1;
   localparam logic [1:0] KIND_END_CONST  = 2'd2;
   localparam logic [1:0] KIND_END_BLOCK  = 2'd3;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_CONST  = 3'd1,
      MODE_CESC   = 3'd2,
      MODE_SLASH  = 3'd3,
      MODE_BLOCK  = 3'd4,
      MODE_LINE   = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic     splice_pending;
      mode_type lex_mode;
      logic     quote_is_double;
      logic     star_seen;
   } lex_state_type;

   // one lexer step: new state and up to two data bytes
   typedef struct packed {
      lex_state_type state;
      logic [1:0]    count;
      logic [7:0]    b0;
      logic [7:0]    b1;
   } lex_out_type;

   // results of one word, handed to the output queue
   typedef struct packed {
      logic [CountWidth-1:0]       count;
      rsp_type [MaxResults-1:0]    slot;
   } batch_type;

   function automatic lex_out_type emit(lex_out_type o, logic [7:0] c);
      lex_out_type r;
      r = o;
      if (o.count == 2'd0) begin
         r.b0 = c;
      end else begin
         r.b1 = c;
      end
      r.count = o.count + 2'd1;
      return r;
   endfunction

   // plain text handling of one byte
   function automatic lex_out_type normal_byte(lex_out_type o, logic [7:0] c);
      lex_out_type r;
      r = o;
      r.state.lex_mode = MODE_NORMAL;
      if (c == CH_SQ || c == CH_DQ) begin
         r = emit(r, c);
         r.state.quote_is_double = (c == CH_DQ);
         r.state.lex_mode = MODE_CONST;
      end else if (c == CH_SLASH) begin
         r.state.lex_mode = MODE_SLASH;
      end else begin
         r = emit(r, c);
      end
      return r;
   endfunction

   // one byte through the lexer, after splices are removed
   function automatic lex_out_type lex_byte(lex_state_type s, logic [7:0] c);
      lex_out_type o;
      logic [7:0]  q;
      o.state = s;
      o.count = 2'd0;
      o.b0    = 8'd0;
      o.b1    = 8'd0;
      q = s.quote_is_double ? CH_DQ : CH_SQ;
      case (s.lex_mode)
         MODE_CONST: begin
            o = emit(o, c);
            if (c == q) begin
               o.state.lex_mode = MODE_NORMAL;
            end else if (c == CH_BSL) begin
               o.state.lex_mode = MODE_CESC;
            end
         end
         MODE_CESC: begin
            o = emit(o, c);
            o.state.lex_mode = MODE_CONST;
         end
         MODE_SLASH: begin
            if (c == CH_STAR) begin
               o.state.lex_mode = MODE_BLOCK;
               o.state.star_seen = 1'b0;
            end else if (c == CH_SLASH) begin
               o.state.lex_mode = MODE_LINE;
            end else begin
               o = emit(o, CH_SLASH);
               o = normal_byte(o, c);
            end
         end
         MODE_BLOCK: begin
            if (c == CH_SLASH && s.star_seen) begin
               o = emit(o, CH_SPACE);
               o.state.lex_mode = MODE_NORMAL;
               o.state.star_seen = 1'b0;
            end else begin
               o.state.star_seen = (c == CH_STAR);
            end
         end
         MODE_LINE: begin
            if (c == CH_NL) begin
               o = emit(o, CH_NL);
               o.state.lex_mode = MODE_NORMAL;
            end
         end
         default: begin
            o = normal_byte(o, c);
         end
      endcase
      return o;
   endfunction

endpackage

@@ design/ccs_lexer.sv @@
// lexer state registers and the per-word result builder
`timescale 1ns / 1ps

module ccs_lexer (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ccs_pkg::req_type    word,
   output ccs_pkg::batch_type  batch
);

   localparam int CW = ccs_pkg::CountWidth;

   ccs_pkg::lex_state_type state_ff;
   ccs_pkg::lex_state_type state_in;

   // build the results of the held word
   always_comb begin
      ccs_pkg::lex_state_type s;
      ccs_pkg::lex_out_type   a;
      ccs_pkg::rsp_type       r;
      logic [1:0]             k;
      logic [CW-1:0]          n;

      s = state_ff;
      a = '0;
      r = '0;
      k = ccs_pkg::KIND_END_OK;
      n = '0;
      batch = '0;

      if (word.end_mark) begin
         // flush a held backslash, then report how the text ended
         if (s.splice_pending) begin
            s.splice_pending = 1'b0;
            a = ccs_pkg::lex_byte(s, ccs_pkg::CH_BSL);
            s = a.state;
            if (a.count >= 2'd1) begin
               r = '{out_byte: a.b0, kind: ccs_pkg::KIND_DATA, last_of_run: 1'b0};
               batch.slot[n[1:0]] = r;
               n = n + 1'b1;
            end
            if (a.count >= 2'd2) begin
               r = '{out_byte: a.b1, kind: ccs_pkg::KIND_DATA, last_of_run: 1'b0};
               batch.slot[n[1:0]] = r;
               n = n + 1'b1;
            end
         end
         case (s.lex_mode)
            ccs_pkg::MODE_CONST, ccs_pkg::MODE_CESC: k = ccs_pkg::KIND_END_CONST;
            ccs_pkg::MODE_BLOCK:                     k = ccs_pkg::KIND_END_BLOCK;
            default:                                 k = ccs_pkg::KIND_END_OK;
         endcase
         if (s.lex_mode == ccs_pkg::MODE_SLASH) begin
            r = '{out_byte: ccs_pkg::CH_SLASH, kind: ccs_pkg::KIND_DATA, last_of_run: 1'b0};
            batch.slot[n[1:0]] = r;
            n = n + 1'b1;
         end
         r = '{out_byte: 8'd0, kind: k, last_of_run: 1'b0};
         batch.slot[n[1:0]] = r;
         n = n + 1'b1;
         s = '0;
      end else begin
         // held backslash before a newline is a splice and vanishes
         if (s.splice_pending && word.in_byte != ccs_pkg::CH_NL) begin
            s.splice_pending = 1'b0;
            a = ccs_pkg::lex_byte(s, ccs_pkg::CH_BSL);
            s = a.state;
            if (a.count >= 2'd1) begin
               r = '{out_byte: a.b0, kind: ccs_pkg::KIND_DATA, last_of_run: 1'b0};
               batch.slot[n[1:0]] = r;
               n = n + 1'b1;
            end
            if (a.count >= 2'd2) begin
               r = '{out_byte: a.b1, kind: ccs_pkg::KIND_DATA, last_of_run: 1'b0};
               batch.slot[n[1:0]] = r;
               n = n + 1'b1;
            end
         end else if (s.splice_pending) begin
            s.splice_pending = 1'b0;
         end else begin
            s = s;
         end

         // current byte: either held as a new backslash or lexed
         if (state_ff.splice_pending && word.in_byte == ccs_pkg::CH_NL) begin
            s = s;
         end else if (word.in_byte == ccs_pkg::CH_BSL) begin
            s.splice_pending = 1'b1;
         end else begin
            a = ccs_pkg::lex_byte(s, word.in_byte);
            s = a.state;
            if (a.count >= 2'd1) begin
               r = '{out_byte: a.b0, kind: ccs_pkg::KIND_DATA, last_of_run: 1'b0};
               batch.slot[n[1:0]] = r;
               n = n + 1'b1;
            end
            if (a.count >= 2'd2) begin
               r = '{out_byte: a.b1, kind: ccs_pkg::KIND_DATA, last_of_run: 1'b0};
               batch.slot[n[1:0]] = r;
               n = n + 1'b1;
            end
         end
      end

      // mark the final result of the word
      if (n != '0) begin
         batch.slot[2'(n - 1'b1)].last_of_run = 1'b1;
      end
      batch.count = n;
      state_in = s;
   end

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/ccs_out_queue.sv @@
// result queue: a word's results drain one per ready cycle
`timescale 1ns / 1ps

module ccs_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  ccs_pkg::batch_type  load_batch,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ccs_pkg::rsp_type    rsp_word
);

   localparam int N  = ccs_pkg::MaxResults;
   localparam int CW = ccs_pkg::CountWidth;

   ccs_pkg::rsp_type [N-1:0] buf_ff;
   ccs_pkg::rsp_type [N-1:0] buf_in;
   logic [CW-1:0]            cnt_ff;
   logic [CW-1:0]            cnt_in;
   logic                     pop;
   logic                     load;

   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_word   = buf_ff[0];
   assign pop        = rsp_valid && rsp_ready;
   assign load_ready = (cnt_ff == '0) || (cnt_ff == CW'(1) && pop);
   assign load       = load_valid && load_ready;

   // load a new batch or shift out the head
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (load) begin
         buf_in = load_batch.slot;
         cnt_in = load_batch.count;
      end else if (pop) begin
         for (int i = 0; i < N - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ design/c_comment_stripper.sv @@
// top level of the comment stripper: input register, lexer and result queue
`timescale 1ns / 1ps

// channel  ports                           word
// input    req_valid req_ready req_word    in_byte, end_mark
// result   rsp_valid rsp_ready rsp_word    out_byte, kind, last_of_run
//
// a word enters the input register, then the lexer turns it into its results
// in one pass and loads them into a four-entry result queue
// one word per cycle while each word gives at most one result and rsp_ready
// is high; a word with more results waits until the queue has drained all
// but its last; reset returns the lexer to plain text and empties both
// registers; result stalls back up through the queue and the input register

module c_comment_stripper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ccs_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ccs_pkg::rsp_type  rsp_word
);

   ccs_pkg::req_type   hold_ff;
   logic               hold_valid_ff;
   ccs_pkg::batch_type batch;
   logic               load_ready;
   logic               step;

   assign step      = hold_valid_ff && load_ready;
   assign req_ready = !hold_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_ff <= req_word;
      end
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         hold_valid_ff <= 1'b1;
      end else if (step) begin
         hold_valid_ff <= 1'b0;
      end
   end

   ccs_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .word  (hold_ff),
      .batch (batch)
   );

   ccs_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load_valid (hold_valid_ff),
      .load_batch (batch),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule
